// ----- design/prf_pkg.sv -----
// ----------------------------------------------------------------------------
// prf_pkg: shared definitions for the polynomial root finder
// Widths, status and register codes, unit request types, guess table.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int MAX_DEGREE = 16;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_DEPTH = MAX_DEGREE + 1;
  localparam int COEF_W     = $clog2(COEF_DEPTH);
  localparam int DEG_W      = $clog2(MAX_DEGREE);
  localparam int CNT_W      = $clog2(COEF_DEPTH + 1);
  localparam int ROW        = 1 << DEG_W;
  localparam int TAB_W      = 2 * DEG_W;
  localparam int TAB_SIZE   = ROW * ROW;
  localparam int DIV_HI     = 31 - FRAC_BITS;

  localparam logic signed [31:0] ONE_FX  = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  localparam logic [1:0] STAT_CONVERGED = 2'd0;
  localparam logic [1:0] STAT_LIMIT     = 2'd1;
  localparam logic [1:0] STAT_INVALID   = 2'd2;

  localparam logic [1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd1;

  localparam logic [30:0] TOL_RESET  = 31'd66;
  localparam logic [15:0] ITER_RESET = 16'd100;

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;

  // multiplier request
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] quo;
  } div_rsp_t;

  // cosine and sine of one starting angle
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } circ_t;

  typedef circ_t [TAB_SIZE-1:0] circ_tab_t;

  // Build the cos/sin table of pi*i/d from a Taylor series in Q30.
  function automatic circ_tab_t build_circle();
    circ_tab_t       tab;
    longint unsigned ang;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ct;
    longint unsigned st;
    longint          cs;
    longint          ss;
    longint          rc;
    longint          rs;
    logic            flip;
    tab = '0;
    for (int d = 1; d <= MAX_DEGREE; d++) begin
      for (int i = 0; i < d; i++) begin
        ang  = (PI_Q30 * 64'(i)) / 64'(d);
        flip = ang > HALF_PI_Q30;
        x    = flip ? PI_Q30 - ang : ang;
        x2   = (x * x) >> 30;
        ct   = Q30_ONE;
        st   = x;
        cs   = longint'(Q30_ONE);
        ss   = longint'(x);
        for (int t = 1; t <= 12; t++) begin
          ct = ((ct * x2) >> 30) / 64'((2 * t - 1) * (2 * t));
          st = ((st * x2) >> 30) / 64'((2 * t) * (2 * t + 1));
          if ((t % 2) == 1) begin
            cs = cs - longint'(ct);
            ss = ss - longint'(st);
          end else begin
            cs = cs + longint'(ct);
            ss = ss + longint'(st);
          end
        end
        if (flip) begin
          cs = -cs;
        end
        rc = (cs + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        rs = (ss + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (rc > longint'(ONE_FX)) rc = longint'(ONE_FX);
        if (rc < -longint'(ONE_FX)) rc = -longint'(ONE_FX);
        if (rs > longint'(ONE_FX)) rs = longint'(ONE_FX);
        if (rs < -longint'(ONE_FX)) rs = -longint'(ONE_FX);
        tab[(d - 1) * ROW + i].c = rc[31:0];
        tab[(d - 1) * ROW + i].s = rs[31:0];
      end
    end
    return tab;
  endfunction

  localparam circ_tab_t CIRCLE = build_circle();

endpackage

// ----- design/polynomial_root_finder.sv -----
// ----------------------------------------------------------------------------
// polynomial_root_finder: Durand-Kerner roots of a real polynomial, Q16.16
// Sequencer around one shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
// Coefficient requests: one per cycle while idle (in_stall low); the last one starts the solve.
// Solve: the divider normalizes each coefficient, each root is seeded, and
// each sweep updates every root of degree n on the shared multiplier and the
// 31-step divider. Up to max_iterations sweeps, then one root per cycle unless
// out_stall holds it; invalid input: 1 result.
// Reset (rst, synchronous): control clears, tolerance 66, max_iterations 100.
module polynomial_root_finder import prf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] coef_value,
  input  logic               coef_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] root_real,
  output logic signed [31:0] root_imag,
  output logic [1:0]         solve_status,
  output logic               root_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_NORM_GO, S_NORM_WAIT, S_BOUND, S_TOL_SQ, S_INIT_GO,
    S_INIT_MUL, S_SWEEP, S_ROOT, S_HORN, S_PROD_SEL, S_PROD, S_QMUL,
    S_DIVR_GO, S_DIVR_WAIT, S_DIVI_GO, S_DIVI_WAIT, S_UPDATE, S_QSQ,
    S_NEXT_ROOT, S_SWEEP_END, S_EMIT, S_EMIT_BAD
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'(SAT_MAX)) return SAT_MAX;
    else if (v < 65'(SAT_MIN)) return SAT_MIN;
    else return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  state_t             state;
  logic signed [31:0] coef [COEF_DEPTH];
  logic signed [31:0] rre [MAX_DEGREE];
  logic signed [31:0] rim [MAX_DEGREE];
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   deg;
  logic [CNT_W-1:0]   e;
  logic [CNT_W-1:0]   a;
  logic               overrun;
  logic [30:0]        tolerance;
  logic [15:0]        max_iter;
  logic               lead_neg;
  logic [31:0]        lead_mag;
  logic [31:0]        big;
  logic signed [31:0] bnd;
  logic [61:0]        tol2;
  logic [15:0]        sweep;
  logic [63:0]        worst;
  logic               stuck;
  logic [1:0]         status;
  logic signed [31:0] z_re, z_im, h_re, h_im, g_re, g_im, d_re, d_im;
  logic signed [31:0] cre, qr, qi;
  logic signed [64:0] t, nr, ni;
  logic [63:0]        den, qs;
  logic [2:0]         ph;

  mul_req_t           mul_req;
  logic signed [63:0] prod;
  logic signed [64:0] prod_sh;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic signed [31:0] quo_s;
  logic signed [31:0] xr, xi, yr, yi;
  logic [CNT_W-1:0]   dm1;
  circ_t              circ;
  logic [DEG_W-1:0]   e_r, a_r;
  logic [COEF_W-1:0]  e_c, a_c;
  logic [64:0]        nr_mag, ni_mag;
  logic [63:0]        qs_sum;
  logic               out_free;
  logic               emit_last;

  assign e_r       = e[DEG_W-1:0];
  assign a_r       = a[DEG_W-1:0];
  assign e_c       = e[COEF_W-1:0];
  assign a_c       = a[COEF_W-1:0];
  assign dm1       = deg - 1'b1;
  assign circ      = CIRCLE[{dm1[DEG_W-1:0], e_r}];
  assign prod_sh   = 65'(prod >>> FRAC_BITS);
  assign quo_s     = signed'({1'b0, div_rsp.quo});
  assign nr_mag    = nr[64] ? -nr : nr;
  assign ni_mag    = ni[64] ? -ni : ni;
  assign qs_sum    = qs + 64'(prod);
  assign out_free  = !out_valid || !out_stall;
  assign emit_last = (e + 1'b1) == deg;
  assign in_stall  = state != S_IDLE;
  assign cfg_ready = 1'b1;

  // complex product operands: Horner uses h*z, the product chain g*d
  assign xr = (state == S_HORN) ? h_re : g_re;
  assign xi = (state == S_HORN) ? h_im : g_im;
  assign yr = (state == S_HORN) ? z_re : d_re;
  assign yi = (state == S_HORN) ? z_im : d_im;

  // select multiplier operands
  always_comb begin
    mul_req = '0;
    case (state)
      S_BOUND: begin
        mul_req.a = signed'({1'b0, tolerance});
        mul_req.b = signed'({1'b0, tolerance});
      end
      S_INIT_GO: begin
        mul_req.a = bnd;
        mul_req.b = circ.s;
      end
      S_HORN, S_PROD: begin
        case (ph)
          3'd0: mul_req = '{a: xr, b: yr};
          3'd1: mul_req = '{a: xi, b: yi};
          3'd2: mul_req = '{a: xr, b: yi};
          3'd3: mul_req = '{a: xi, b: yr};
          default: mul_req = '0;
        endcase
      end
      S_QMUL: begin
        case (ph)
          3'd0: mul_req = '{a: g_re, b: g_re};
          3'd1: mul_req = '{a: g_im, b: g_im};
          3'd2: mul_req = '{a: h_re, b: g_re};
          3'd3: mul_req = '{a: h_im, b: g_im};
          3'd4: mul_req = '{a: h_im, b: g_re};
          3'd5: mul_req = '{a: h_re, b: g_im};
          default: mul_req = '0;
        endcase
      end
      S_QSQ: begin
        case (ph)
          3'd0: mul_req = '{a: qr, b: qr};
          3'd1: mul_req = '{a: qi, b: qi};
          default: mul_req = '0;
        endcase
      end
      default: mul_req = '0;
    endcase
  end

  // select divider request
  always_comb begin
    div_req = '0;
    case (state)
      S_NORM_GO: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(abs32(coef[e_c]));
        div_req.den   = 64'(lead_mag);
      end
      S_DIVR_GO: begin
        div_req.start = 1'b1;
        div_req.num   = nr_mag[63:0];
        div_req.den   = den;
      end
      S_DIVI_GO: begin
        div_req.start = 1'b1;
        div_req.num   = ni_mag[63:0];
        div_req.den   = den;
      end
      default: div_req = '0;
    endcase
  end

  prf_mult u_mult (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  prf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      overrun   <= 1'b0;
      out_valid <= 1'b0;
      tolerance <= TOL_RESET;
      max_iter  <= ITER_RESET;
    end else begin
      // drop a taken result unless a new one loads this cycle
      if (out_valid && !out_stall && state != S_EMIT && state != S_EMIT_BAD) begin
        out_valid <= 1'b0;
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOLERANCE: tolerance <= cfg_data[30:0];
          CFG_MAX_ITER:  max_iter  <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (count < CNT_W'(COEF_DEPTH)) begin
              coef[count[COEF_W-1:0]] <= coef_value;
              count <= count + 1'b1;
            end else begin
              overrun <= 1'b1;
            end
            if (coef_last) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          count    <= '0;
          overrun  <= 1'b0;
          deg      <= count - 1'b1;
          lead_neg <= coef[0][31];
          lead_mag <= abs32(coef[0]);
          e        <= '0;
          big      <= '0;
          if (overrun || count < CNT_W'(2) || coef[0] == 32'sd0) begin
            state <= S_EMIT_BAD;
          end else begin
            state <= S_NORM_GO;
          end
        end
        S_NORM_GO: state <= S_NORM_WAIT;
        S_NORM_WAIT: begin
          if (div_rsp.done) begin
            coef[e_c] <= (coef[e_c][31] ^ lead_neg) ? -quo_s : quo_s;
            if ({1'b0, div_rsp.quo} > big) begin
              big <= {1'b0, div_rsp.quo};
            end
            if (e == deg) begin
              e     <= '0;
              state <= S_BOUND;
            end else begin
              e     <= e + 1'b1;
              state <= S_NORM_GO;
            end
          end
        end
        S_BOUND: begin
          bnd   <= sat32(65'(big) + 65'(ONE_FX));
          state <= S_TOL_SQ;
        end
        S_TOL_SQ: begin
          tol2  <= prod[61:0];
          state <= S_INIT_GO;
        end
        S_INIT_GO: begin
          rre[e_r] <= circ.c;
          state    <= S_INIT_MUL;
        end
        S_INIT_MUL: begin
          rim[e_r] <= sat32(prod_sh);
          if (emit_last) begin
            e     <= '0;
            sweep <= '0;
            state <= S_SWEEP;
          end else begin
            e     <= e + 1'b1;
            state <= S_INIT_GO;
          end
        end
        S_SWEEP: begin
          e <= '0;
          if (sweep == max_iter) begin
            status <= STAT_LIMIT;
            state  <= S_EMIT;
          end else begin
            worst <= '0;
            stuck <= 1'b0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          z_re  <= rre[e_r];
          z_im  <= rim[e_r];
          h_re  <= coef[0];
          h_im  <= '0;
          a     <= CNT_W'(1);
          ph    <= '0;
          state <= S_HORN;
        end
        // complex product on the shared multiplier, four issues
        S_HORN, S_PROD: begin
          ph <= (ph == 3'd4) ? 3'd0 : ph + 1'b1;
          case (ph)
            3'd1, 3'd3: t <= prod_sh;
            3'd2: cre <= sat32(t - prod_sh);
            3'd4: begin
              if (state == S_HORN) begin
                h_re <= sat32(65'(cre) + 65'(coef[a_c]));
                h_im <= sat32(t + prod_sh);
                if (a == deg) begin
                  a     <= '0;
                  g_re  <= ONE_FX;
                  g_im  <= '0;
                  state <= S_PROD_SEL;
                end else begin
                  a <= a + 1'b1;
                end
              end else begin
                g_re  <= cre;
                g_im  <= sat32(t + prod_sh);
                a     <= a + 1'b1;
                state <= S_PROD_SEL;
              end
            end
            default: ;
          endcase
        end
        S_PROD_SEL: begin
          if (a == deg) begin
            ph    <= '0;
            state <= S_QMUL;
          end else if (a == e) begin
            a <= a + 1'b1;
          end else begin
            d_re  <= sat32(65'(z_re) - 65'(rre[a_r]));
            d_im  <= sat32(65'(z_im) - 65'(rim[a_r]));
            ph    <= '0;
            state <= S_PROD;
          end
        end
        // denominator |g|^2 and numerator parts of h*conj(g)
        S_QMUL: begin
          ph <= (ph == 3'd6) ? 3'd0 : ph + 1'b1;
          case (ph)
            3'd1: den <= 64'(prod);
            3'd2: den <= den + 64'(prod);
            3'd3: nr  <= 65'(prod);
            3'd4: nr  <= nr + 65'(prod);
            3'd5: ni  <= 65'(prod);
            3'd6: begin
              ni <= ni - 65'(prod);
              if (den == 64'd0) begin
                stuck <= 1'b1;
                state <= S_NEXT_ROOT;
              end else begin
                state <= S_DIVR_GO;
              end
            end
            default: ;
          endcase
        end
        S_DIVR_GO: state <= S_DIVR_WAIT;
        S_DIVR_WAIT: begin
          if (div_rsp.done) begin
            qr    <= nr[64] ? quo_s : -quo_s;
            state <= S_DIVI_GO;
          end
        end
        S_DIVI_GO: state <= S_DIVI_WAIT;
        S_DIVI_WAIT: begin
          if (div_rsp.done) begin
            qi    <= ni[64] ? quo_s : -quo_s;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          rre[e_r] <= sat32(65'(z_re) + 65'(qr));
          rim[e_r] <= sat32(65'(z_im) + 65'(qi));
          ph       <= '0;
          state    <= S_QSQ;
        end
        // track the largest squared correction
        S_QSQ: begin
          ph <= (ph == 3'd2) ? 3'd0 : ph + 1'b1;
          case (ph)
            3'd1: qs <= 64'(prod);
            3'd2: begin
              if (qs_sum > worst) begin
                worst <= qs_sum;
              end
              state <= S_NEXT_ROOT;
            end
            default: ;
          endcase
        end
        S_NEXT_ROOT: begin
          if (emit_last) begin
            state <= S_SWEEP_END;
          end else begin
            e     <= e + 1'b1;
            state <= S_ROOT;
          end
        end
        S_SWEEP_END: begin
          sweep <= sweep + 1'b1;
          if (!stuck && worst <= 64'(tol2)) begin
            status <= STAT_CONVERGED;
            e      <= '0;
            state  <= S_EMIT;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            root_real    <= rre[e_r];
            root_imag    <= rim[e_r];
            solve_status <= status;
            root_last    <= emit_last;
            out_valid    <= 1'b1;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              e <= e + 1'b1;
            end
          end
        end
        S_EMIT_BAD: begin
          if (out_free) begin
            root_real    <= '0;
            root_imag    <= '0;
            solve_status <= STAT_INVALID;
            root_last    <= 1'b1;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && solve_status == STAT_INVALID) |-> root_last)
    else $error("invalid result not marked last");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(COEF_DEPTH))
    else $error("coefficient count past store depth");
  a_solve_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && coef_last) |=> in_stall)
    else $error("request taken while solve starts");
`endif

endmodule

// ----- design/prf_mult.sv -----
// ----------------------------------------------------------------------------
// prf_mult: shared signed multiplier
// One 32x32 signed product per cycle, exact 64-bit result registered.
// ----------------------------------------------------------------------------
module prf_mult import prf_pkg::*; (
  input  logic               clk,
  input  mul_req_t           req,
  output logic signed [63:0] prod
);

  // register the exact product
  always_ff @(posedge clk) begin
    prod <= 64'(req.a) * 64'(req.b);
  end

endmodule

// ----- design/prf_div.sv -----
// ----------------------------------------------------------------------------
// prf_div: iterative fixed-point divider
// floor(num * 2^FRAC_BITS / den) saturated to 2^31-1, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module prf_div import prf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [63:0] rem;
  logic [63:0] den_r;
  logic [30:0] low;
  logic [30:0] quo;
  logic [4:0]  left;
  logic        over;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        fits;

  // quotient would not fit in 31 bits
  assign over  = {{DIV_HI{1'b0}}, req.num} >= {req.den, {DIV_HI{1'b0}}};
  assign trial = {rem, low[30]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  // restoring long division
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        den_r <= req.den;
        done  <= over;
        if (over) begin
          quo <= '1;
        end else begin
          rem  <= req.num >> DIV_HI;
          low  <= {req.num[DIV_HI-1:0], {FRAC_BITS{1'b0}}};
          left <= 5'd31;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= fits ? diff[63:0] : trial[63:0];
        quo  <= {quo[29:0], fits};
        low  <= {low[29:0], 1'b0};
        left <= left - 1'b1;
        done <= (left == 5'd1);
        if (left == 5'd1) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp = '{busy: busy, done: done, quo: quo};

endmodule
